// ----- src/i2cm_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int COUNTER_WIDTH = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int BIT_CNT_W     = 4;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] OPC_START = 3'd1;
	localparam logic [2:0] OPC_STOP  = 3'd2;
	localparam logic [2:0] OPC_WRITE = 3'd3;
	localparam logic [2:0] OPC_READ  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PUSH    = 2'd3;

	localparam logic [CFG_W-1:0] HALF_RESET    = 16'd5;
	localparam logic [CFG_W-1:0] QUARTER_RESET = 16'd2;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       rd_nack;
		logic       scl_in;
		logic       sda_in;
	} in_req_t;

	typedef struct packed {
		logic       scl_level;
		logic       scl_enable;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rx_byte;
	} out_res_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       rd_nack;
		logic       scl_in;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic  push;
		tick_t data;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		tick_t data;
	} q_head_t;

endpackage

// ----- src/i2cm_front.sv -----
// Input side: request handshake and opcode classification.
`timescale 1ns / 1ps

module i2cm_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  i2cm_pkg::in_req_t in_data,
	input  logic             q_full,
	output i2cm_pkg::q_push_t q_push
);
	import i2cm_pkg::*;

	cmd_t cmd;

	always_comb begin
		unique case (in_data.opcode)
			OPC_START: cmd = CMD_START;
			OPC_STOP:  cmd = CMD_STOP;
			OPC_WRITE: cmd = CMD_WRITE;
			OPC_READ:  cmd = CMD_READ;
			default:   cmd = CMD_NONE;
		endcase
	end

	assign in_ready               = ~q_full;
	assign q_push.push            = in_valid & ~q_full;
	assign q_push.data.cmd        = cmd;
	assign q_push.data.tx_byte    = in_data.tx_byte;
	assign q_push.data.rd_nack    = in_data.rd_nack;
	assign q_push.data.scl_in     = in_data.scl_in;
	assign q_push.data.sda_in     = in_data.sda_in;

endmodule

// ----- src/i2cm_queue.sv -----
// Short request queue between the front and the bus sequencer.
`timescale 1ns / 1ps

module i2cm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cm_pkg::q_push_t q_push,
	output logic              q_full,
	output i2cm_pkg::q_head_t q_head,
	input  logic              q_pop
);
	import i2cm_pkg::*;

	tick_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign q_full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_head.valid = (count_q != '0);
	assign q_head.data  = mem_q[rd_ptr_q];
	assign do_push      = q_push.push & ~q_full;
	assign do_pop       = q_pop & q_head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/i2cm_back.sv -----
// Bus sequencer: phase machine, configuration registers and result register.
`timescale 1ns / 1ps

module i2cm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cm_pkg::CFG_W-1:0]     cfg_data,
	input  i2cm_pkg::q_head_t              q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output i2cm_pkg::out_res_t             out_data
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		P_IDLE,
		P_ST_D1, P_ST_W, P_ST_D2, P_ST_D3,
		P_SP_D1, P_SP_W, P_SP_D2, P_SP_D3,
		P_WB_D1, P_WB_W, P_WB_D2, P_WB_D3,
		P_RB_D1, P_RB_W, P_RB_D2, P_RB_D3, P_RB_D4
	} phase_t;

	localparam logic [BIT_CNT_W-1:0] BITS_FULL = BIT_CNT_W'(BITS_PER_BYTE);
	localparam logic [BIT_CNT_W-1:0] BITS_LAST = BIT_CNT_W'(BITS_PER_BYTE - 1);

	logic [CFG_W-1:0]         half_q;
	logic [CFG_W-1:0]         quarter_q;
	logic [CFG_W-1:0]         lim_m1_q;
	logic                     push_pull_q;

	phase_t                   phase_q, phase_n;
	cmd_t                     command_q, command_n;
	logic [BIT_CNT_W-1:0]     bit_count_q, bit_count_n;
	logic [7:0]               shift_q, shift_n;
	logic [COUNTER_WIDTH-1:0] delay_q, delay_n;
	logic [COUNTER_WIDTH-1:0] stretch_q, stretch_n;
	logic                     nack_q, nack_n;
	logic                     scl_q, scl_n;
	logic                     sda_q, sda_n;
	logic [1:0]               status_q, status_n;
	logic [7:0]               rx_q, rx_n;
	logic                     done_n;
	logic                     out_valid_q;
	out_res_t                 out_data_q;

	tick_t                    t;
	logic                     dly_end;
	logic                     wt_timeout;
	logic [COUNTER_WIDTH-1:0] half_c;
	logic [COUNTER_WIDTH-1:0] quarter_c;

	assign t          = q_head.data;
	assign q_pop      = q_head.valid & (~out_valid_q | out_ready);
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign dly_end    = (delay_q <= COUNTER_WIDTH'(1));
	assign wt_timeout = (COUNTER_WIDTH'(stretch_q) >= COUNTER_WIDTH'(lim_m1_q));
	assign half_c     = COUNTER_WIDTH'(half_q);
	assign quarter_c  = COUNTER_WIDTH'(quarter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= HALF_RESET;
			quarter_q   <= QUARTER_RESET;
			lim_m1_q    <= TIMEOUT_RESET - 1'b1;
			push_pull_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_HALF:    half_q <= cfg_data;
				CFG_QUARTER: quarter_q <= cfg_data;
				CFG_TIMEOUT: lim_m1_q <= (cfg_data == '0) ? '0 : cfg_data - 1'b1;
				CFG_PUSH:    push_pull_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		phase_n     = phase_q;
		command_n   = command_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		delay_n     = delay_q;
		stretch_n   = stretch_q;
		nack_n      = nack_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		status_n    = status_q;
		rx_n        = rx_q;
		done_n      = 1'b0;
		unique case (phase_q)
			P_IDLE: begin
				if (t.cmd != CMD_NONE) begin
					command_n   = t.cmd;
					bit_count_n = '0;
					unique case (t.cmd)
						CMD_START: begin
							sda_n   = 1'b1;
							scl_n   = 1'b1;
							phase_n = P_ST_D1;
							delay_n = half_c;
						end
						CMD_STOP: begin
							sda_n   = 1'b0;
							phase_n = P_SP_D1;
							delay_n = quarter_c;
						end
						CMD_WRITE: begin
							nack_n  = 1'b0;
							sda_n   = t.tx_byte[7];
							shift_n = {t.tx_byte[6:0], 1'b0};
							phase_n = P_WB_D1;
							delay_n = quarter_c;
						end
						default: begin
							shift_n = '0;
							rx_n    = '0;
							nack_n  = t.rd_nack;
							sda_n   = 1'b1;
							phase_n = P_RB_D1;
							delay_n = quarter_c;
						end
					endcase
				end
			end
			P_ST_D1: begin
				if (dly_end) begin
					phase_n   = P_ST_W;
					stretch_n = '0;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_SP_D1, P_WB_D1, P_RB_D1: begin
				if (dly_end) begin
					scl_n     = 1'b1;
					stretch_n = '0;
					phase_n   = (phase_q == P_SP_D1) ? P_SP_W :
					            (phase_q == P_WB_D1) ? P_WB_W : P_RB_W;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_ST_W, P_SP_W, P_WB_W, P_RB_W: begin
				if (t.scl_in) begin
					unique case (phase_q)
						P_ST_W: begin
							sda_n   = 1'b0;
							phase_n = P_ST_D2;
							delay_n = half_c;
						end
						P_SP_W: begin
							phase_n = P_SP_D2;
							delay_n = half_c;
						end
						P_WB_W: begin
							phase_n = P_WB_D2;
							delay_n = half_c;
						end
						default: begin
							phase_n = P_RB_D2;
							delay_n = quarter_c;
						end
					endcase
				end else begin
					stretch_n = stretch_q + 1'b1;
					if (wt_timeout) begin
						phase_n  = P_IDLE;
						status_n = ST_TIMEOUT;
						done_n   = 1'b1;
					end
				end
			end
			P_ST_D2, P_WB_D2: begin
				if (dly_end) begin
					scl_n   = 1'b0;
					phase_n = (phase_q == P_ST_D2) ? P_ST_D3 : P_WB_D3;
					delay_n = quarter_c;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_ST_D3, P_SP_D3: begin
				if (dly_end) begin
					phase_n  = P_IDLE;
					status_n = ST_OK;
					done_n   = 1'b1;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_SP_D2: begin
				if (dly_end) begin
					sda_n   = 1'b1;
					phase_n = P_SP_D3;
					delay_n = half_c;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_WB_D3: begin
				if (dly_end) begin
					if (command_q == CMD_WRITE && bit_count_q < BITS_FULL) begin
						bit_count_n = bit_count_q + 1'b1;
						delay_n     = quarter_c;
						if (bit_count_q < BITS_LAST) begin
							sda_n   = shift_q[7];
							shift_n = {shift_q[6:0], 1'b0};
							phase_n = P_WB_D1;
						end else begin
							sda_n   = 1'b1;
							phase_n = P_RB_D1;
						end
					end else begin
						phase_n  = P_IDLE;
						status_n = ST_OK;
						done_n   = 1'b1;
					end
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_RB_D2: begin
				if (dly_end) begin
					if (command_q == CMD_READ && bit_count_q < BITS_FULL) begin
						shift_n = {shift_q[6:0], t.sda_in};
						rx_n    = {shift_q[6:0], t.sda_in};
					end else begin
						nack_n = t.sda_in;
					end
					phase_n = P_RB_D3;
					delay_n = quarter_c;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_RB_D3: begin
				if (dly_end) begin
					scl_n   = 1'b0;
					phase_n = P_RB_D4;
					delay_n = quarter_c;
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			P_RB_D4: begin
				if (dly_end) begin
					if (command_q == CMD_READ && bit_count_q < BITS_FULL) begin
						bit_count_n = bit_count_q + 1'b1;
						delay_n     = quarter_c;
						if (bit_count_q < BITS_LAST) begin
							sda_n   = 1'b1;
							phase_n = P_RB_D1;
						end else begin
							sda_n   = nack_q;
							phase_n = P_WB_D1;
						end
					end else begin
						phase_n  = P_IDLE;
						status_n = nack_q ? ST_NACK : ST_OK;
						done_n   = 1'b1;
					end
				end else begin
					delay_n = delay_q - 1'b1;
				end
			end
			default: phase_n = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			command_q   <= CMD_NONE;
			bit_count_q <= '0;
			shift_q     <= '0;
			delay_q     <= '0;
			stretch_q   <= '0;
			nack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			status_q    <= ST_OK;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (q_pop) begin
			phase_q                <= phase_n;
			command_q              <= command_n;
			bit_count_q            <= bit_count_n;
			shift_q                <= shift_n;
			delay_q                <= delay_n;
			stretch_q              <= stretch_n;
			nack_q                 <= nack_n;
			scl_q                  <= scl_n;
			sda_q                  <= sda_n;
			status_q               <= status_n;
			rx_q                   <= rx_n;
			out_valid_q            <= 1'b1;
			out_data_q.scl_level   <= scl_n;
			out_data_q.scl_enable  <= push_pull_q | ~scl_n;
			out_data_q.sda_level   <= sda_n;
			out_data_q.sda_enable  <= push_pull_q | ~sda_n;
			out_data_q.busy_res    <= (phase_n != P_IDLE);
			out_data_q.done_res    <= done_n;
			out_data_q.status      <= status_n;
			out_data_q.rx_byte     <= rx_n;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.done_res |-> !out_data_q.busy_res)
		else $error("done reported while still busy");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BITS_FULL)
		else $error("bit counter past byte length");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !q_pop)
		else $error("sequencer advanced while result stalled");

	a_idle_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_data_q.busy_res == (phase_q != P_IDLE))
		else $error("busy flag disagrees with phase");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && phase_q == P_IDLE |=> !out_data_q.done_res)
		else $error("done pulse without a running command");

endmodule

// ----- src/i2c_master_bit_engine.sv -----
// I2C master bit engine top level: front, request queue and bus sequencer.
// An accepted tick request enters the queue, then the result register when popped.
// Throughput: one tick request per cycle unless a result stalls (one-step phase update).
// Results leave in acceptance order; a stalled result holds while the queue absorbs requests.
// Reset (arst_n low, asynchronous) empties the queue, idles the sequencer with both lines
// released, and restores the configuration registers to their defaults.
`timescale 1ns / 1ps

module i2c_master_bit_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  i2cm_pkg::in_req_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output i2cm_pkg::out_res_t             out_data
);
	import i2cm_pkg::*;

	q_push_t q_push;
	q_head_t q_head;
	logic    q_full;
	logic    q_pop;

	i2cm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push)
	);

	i2cm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.q_head (q_head),
		.q_pop  (q_pop)
	);

	i2cm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule
